[hdl/box_blur_3x3_rgb_top_defines.svh]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// The condition holds at every clock edge.
`define BB3_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger is seen, the consequence holds at the same edge.
`define BB3_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// When the trigger is seen, the consequence holds at the next edge.
`define BB3_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bb3_pkg.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB package
// Shared constants, types and small arithmetic helpers of the blur block.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W     = 13;
  localparam int ROW_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t above;
    pixel_t middle;
  } line_col_t;

  typedef struct packed {
    logic shift;
    logic sum;
    logic mul;
    logic top_edge;
    logic bottom_edge;
    logic left_edge;
    logic right_edge;
  } win_ctl_t;

  // Rounded-up 2^16/cnt; exact for every sum of up to nine 8-bit values.
  function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] bb3_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hdl/bb3_line_store.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB line store
// Two image rows in one memory; each entry is read and then written back with
// the middle row moved up and the new pixel placed as the middle row.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_top_defines.svh"

module bb3_line_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [bb3_pkg::COL_W-1:0] addr,
  input  logic                     wr_en,
  input  bb3_pkg::pixel_t          wr_pix,
  output bb3_pkg::line_col_t       rd_col
);
  import bb3_pkg::*;

  line_col_t        mem [MAX_WIDTH];
  logic [COL_W-1:0] addr_q;
  line_col_t        wr_col;

  always_comb begin
    wr_col.above  = rd_col.middle;
    wr_col.middle = wr_pix;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_col <= mem[addr];
      addr_q <= addr;
    end
    if (wr_en) begin
      mem[addr_q] <= wr_col;
    end
  end

  `BB3_ASSERT_HOLDS(a_no_rd_wr_overlap, !(rd_en && wr_en), "line store read and write overlap")
  `BB3_ASSERT_SAME(a_wr_after_rd, wr_en, $past(rd_en), "line store write without a read")

endmodule

[hdl/bb3_window.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB window and mean
// Holds the 3x3 window, sums the pixels inside the image and divides each
// channel sum by the pixel count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic                clk,
  input  logic                rst,
  input  bb3_pkg::win_ctl_t   ctl,
  input  bb3_pkg::line_col_t  col,
  input  bb3_pkg::pixel_t     pix,
  output bb3_pkg::pixel_t     mean
);
  import bb3_pkg::*;

  pixel_t             win [3][3];
  logic [SUM_W-1:0]   sum_red;
  logic [SUM_W-1:0]   sum_green;
  logic [SUM_W-1:0]   sum_blue;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum_red_next;
  logic [SUM_W-1:0]   sum_green_next;
  logic [SUM_W-1:0]   sum_blue_next;
  logic [CNT_W-1:0]   cnt_next;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_red;
  logic [PROD_W-1:0]  prod_green;
  logic [PROD_W-1:0]  prod_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (ctl.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= col.above;
      win[1][2] <= col.middle;
      win[2][2] <= pix;
    end
  end

  // Row sums first, then the three rows, to keep the adder chain short.
  always_comb begin
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [SUM_W-1:0] row_red   [3];
    logic [SUM_W-1:0] row_green [3];
    logic [SUM_W-1:0] row_blue  [3];
    logic [CNT_W-1:0] row_cnt   [3];
    row_ok = {!ctl.bottom_edge, 1'b1, !ctl.top_edge};
    col_ok = {!ctl.right_edge, 1'b1, !ctl.left_edge};
    for (int r = 0; r < 3; r++) begin
      row_red[r]   = '0;
      row_green[r] = '0;
      row_blue[r]  = '0;
      row_cnt[r]   = '0;
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          row_red[r]   = row_red[r] + SUM_W'(win[r][c].red);
          row_green[r] = row_green[r] + SUM_W'(win[r][c].green);
          row_blue[r]  = row_blue[r] + SUM_W'(win[r][c].blue);
          row_cnt[r]   = row_cnt[r] + CNT_W'(1);
        end
      end
    end
    sum_red_next   = row_red[0] + row_red[1] + row_red[2];
    sum_green_next = row_green[0] + row_green[1] + row_green[2];
    sum_blue_next  = row_blue[0] + row_blue[1] + row_blue[2];
    cnt_next       = row_cnt[0] + row_cnt[1] + row_cnt[2];
  end

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      sum_red   <= sum_red_next;
      sum_green <= sum_green_next;
      sum_blue  <= sum_blue_next;
      cnt       <= cnt_next;
    end
  end

  always_comb begin
    recip      = bb3_recip(cnt);
    prod_red   = PROD_W'(sum_red) * PROD_W'(recip);
    prod_green = PROD_W'(sum_green) * PROD_W'(recip);
    prod_blue  = PROD_W'(sum_blue) * PROD_W'(recip);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      mean.red   <= prod_red[RECIP_SHIFT +: 8];
      mean.green <= prod_green[RECIP_SHIFT +: 8];
      mean.blue  <= prod_blue[RECIP_SHIFT +: 8];
    end
  end

endmodule

[hdl/box_blur_3x3_rgb_top.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB top level
// Channel  Direction  Content
// s_axis   in         tuser: opcode; tdata: red_in, green_in, blue_in
// m_axis   out        tdata: red_out, green_out, blue_out; tlast: last_pixel
// cfg      in         write of image_width (index 0) or image_height (index 1)
//
// A pixel that yields a result goes through these steps in order: accept with
// line store read, store write-back with window shift, masked sum, reciprocal
// multiply, and the load of the output register. A pixel without a result
// ends after the store write-back, and a flush ignored before the image is
// complete is accepted and leaves the state unchanged. The output register
// holds one result; the block waits in the load step while it is full and
// not taken. Reset needs no pass over the line store.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_top_defines.svh"

module box_blur_3x3_rgb_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                         s_axis_tuser,  // opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // red_out, green_out, blue_out
  output logic                         m_axis_tlast
);
  import bb3_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMW  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic [COL_W-1:0]     in_col;
  logic [ROW_W-1:0]     in_row;
  logic [COL_W-1:0]     out_col;
  logic [OUT_ROW_W-1:0] out_row;
  pixel_t               pix_hold;
  logic                 emit_hold;
  pixel_t               out_pix;
  logic                 out_last;
  pixel_t               in_pix;
  pixel_t               mean;
  line_col_t            rd_col;
  win_ctl_t             win_ctl;
  logic                 in_accept;
  logic                 draining;
  logic                 take;
  logic                 emit_now;
  logic                 in_col_last;
  logic                 out_col_last;
  logic                 out_row_last;
  logic                 last;
  logic                 out_free;
  logic                 out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign draining      = (in_row >= image_height);
  assign take          = in_accept && (draining || s_axis_tuser == OP_PIXEL);
  assign emit_now      = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);

  assign in_col_last  = (DIM_W'(in_col) + DIM_W'(1) >= image_width);
  assign out_col_last = (DIM_W'(out_col) + DIM_W'(1) >= image_width);
  assign out_row_last = (DIM_W'(out_row) + DIM_W'(1) >= image_height);
  assign last         = out_row_last && out_col_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_OUT) && out_free;

  always_comb begin
    in_pix.red   = s_axis_tdata[7:0];
    in_pix.green = s_axis_tdata[15:8];
    in_pix.blue  = s_axis_tdata[23:16];
  end

  always_comb begin
    win_ctl.shift       = (state == ST_RMW);
    win_ctl.sum         = (state == ST_SUM);
    win_ctl.mul         = (state == ST_MUL);
    win_ctl.top_edge    = (out_row == '0);
    win_ctl.bottom_edge = out_row_last;
    win_ctl.left_edge   = (out_col == '0);
    win_ctl.right_edge  = out_col_last;
  end

  bb3_line_store u_line_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (take),
    .addr   (in_col),
    .wr_en  (state == ST_RMW),
    .wr_pix (pix_hold),
    .rd_col (rd_col)
  );

  bb3_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctl  (win_ctl),
    .col  (rd_col),
    .pix  (pix_hold),
    .mean (mean)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        state_next = emit_hold ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_hold  <= draining ? '0 : in_pix;
      emit_hold <= emit_now;
    end
  end

  // Writing either dimension abandons the image in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= bb3_clamp(cfg_data, WIDTH_MAX);
        REG_IMAGE_HEIGHT: image_height <= bb3_clamp(cfg_data, HEIGHT_MAX);
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (state == ST_RMW) begin
        if (in_col_last) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (out_load) begin
        if (last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row + OUT_ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix  <= mean;
      out_last <= last;
    end
  end

  assign m_axis_tdata = {out_pix.blue, out_pix.green, out_pix.red};
  assign m_axis_tlast = out_last;

  `BB3_ASSERT_HOLDS(a_col_in_range, DIM_W'(in_col) < image_width, "input column beyond width")
  `BB3_ASSERT_NEXT(a_flush_ignored, in_accept && s_axis_tuser == OP_FLUSH && !draining && !cfg_we, state == ST_IDLE && $stable(in_col) && $stable(in_row), "early flush changed state")
  `BB3_ASSERT_NEXT(a_no_overwrite, state == ST_OUT && m_axis_tvalid && !m_axis_tready, state == ST_OUT, "result register overwritten")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB testbench
// Drives raster-order pixel and flush items into the blur block and checks
// every result against a cycle-free model of the 3x3 truncated channel mean,
// or against the table value for typed rows. A directed table covers reset
// values, register clamping, abandoned images, single-pixel images and flat
// images, followed by the opening items of the two largest image shapes and
// then random images of small size. Random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import bb3_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int CALM_ITEMS     = 150;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LARGE_ITEMS    = 40;

  typedef enum bit {OP_PIXEL = 1'b0, OP_FLUSH = 1'b1} blur_op_e;
  typedef enum bit {ROW_ITEM = 1'b0, ROW_WRITE = 1'b1} row_kind_e;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       last;
  } blur_result_t;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [DIM_W-1:0]       reg_val;
    blur_op_e               op;
    bit [7:0]               red;
    bit [7:0]               green;
    bit [7:0]               blue;
    bit                     typed;
    blur_result_t           want;
  } stim_row_t;

  localparam blur_result_t NO_RES     = '0;
  localparam blur_result_t WHITE_MID  = '{8'd255, 8'd255, 8'd255, 1'b0};
  localparam blur_result_t WHITE_LAST = '{8'd255, 8'd255, 8'd255, 1'b1};
  localparam blur_result_t SOLO_LAST  = '{8'd255, 8'd0, 8'd128, 1'b1};

  localparam int DIR_ROWS = 31;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd170, 8'd85,  8'd1,   1'b0, NO_RES},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd9,   8'd9,   8'd9,   1'b1, SOLO_LAST},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, NO_RES},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  13'd2, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 13'd2, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_MID},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, WHITE_MID},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b1, WHITE_MID},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, WHITE_LAST},
    '{ROW_WRITE, REG_IMAGE_WIDTH,  13'd3, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_WRITE, REG_IMAGE_HEIGHT, 13'd2, OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd10,  8'd200, 8'd33,  1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd255, 8'd0,   8'd7,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd1,   8'd2,   8'd3,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd254, 8'd128, 8'd64,  1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd0,   8'd255, 8'd100, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd77,  8'd13,  8'd250, 1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_PIXEL, 8'd33,  8'd66,  8'd99,  1'b0, NO_RES},
    '{ROW_ITEM,  REG_IMAGE_WIDTH,  13'd0, OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, NO_RES}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;   // red_in, green_in, blue_in
  logic                 s_axis_tuser = 1'b0; // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [23:0]          m_axis_tdata;        // red_out, green_out, blue_out
  logic                 m_axis_tlast;

  // Model state: image size, line stores, window and raster counters.
  bit [DIM_W-1:0] img_w = 13'd640;
  bit [DIM_W-1:0] img_h = 13'd480;
  bit [23:0]      line_above  [MAX_WIDTH];
  bit [23:0]      line_middle [MAX_WIDTH];
  bit [23:0]      win [3][3];
  bit [11:0]      px_col;
  bit [12:0]      px_row;
  bit [11:0]      res_col;
  bit [11:0]      res_row;

  blur_result_t pending_means [$];
  int           fail_count = 0;
  int           useful_items = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           rdy_hold = 0;
  int           idle_cycles = 0;

  box_blur_3x3_rgb_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [7:0] rand_chan();
    bit [7:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'd0;
      1:       v = 8'd255;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  function automatic void clear_raster();
    px_col  = '0;
    px_row  = '0;
    res_col = '0;
    res_row = '0;
  endfunction

  function automatic void box_mean_step(input blur_op_e op, input bit [23:0] pix_in,
                                        output bit ignored, output bit produced,
                                        output blur_result_t res);
    bit        draining;
    bit        emit;
    bit [23:0] pix;
    bit [23:0] p;
    bit [11:0] col;
    int        r;
    int        c;
    int        cnt;
    int        sr;
    int        sg;
    int        sb;
    draining = (px_row >= img_h);
    ignored  = 1'b0;
    produced = 1'b0;
    res      = '0;
    if (!draining && op == OP_FLUSH) begin
      ignored = 1'b1;
      return;
    end
    pix = draining ? 24'd0 : pix_in;
    col = px_col;
    for (int dr = 0; dr < 3; dr++) begin
      win[dr][0] = win[dr][1];
      win[dr][1] = win[dr][2];
    end
    win[0][2] = line_above[col];
    win[1][2] = line_middle[col];
    win[2][2] = pix;
    line_above[col]  = line_middle[col];
    line_middle[col] = pix;

    emit = (px_row >= 13'd2) || (px_row == 13'd1 && px_col >= 12'd1);
    if (int'(px_col) + 1 >= int'(img_w)) begin
      px_col = '0;
      px_row = px_row + 13'd1;
    end else begin
      px_col = px_col + 12'd1;
    end
    if (!emit) begin
      return;
    end

    r   = res_row;
    c   = res_col;
    cnt = 0;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    for (int dr = 0; dr < 3; dr++) begin
      if (dr == 0 && r == 0) continue;
      if (dr == 2 && r + 1 >= int'(img_h)) continue;
      for (int dc = 0; dc < 3; dc++) begin
        if (dc == 0 && c == 0) continue;
        if (dc == 2 && c + 1 >= int'(img_w)) continue;
        p   = win[dr][dc];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;

    produced  = 1'b1;
    res.red   = 8'(sr / cnt);
    res.green = 8'(sg / cnt);
    res.blue  = 8'(sb / cnt);
    res.last  = (r + 1 >= int'(img_h)) && (c + 1 >= int'(img_w));
    if (c + 1 >= int'(img_w)) begin
      res_col = '0;
      res_row = res_row + 12'd1;
    end else begin
      res_col = res_col + 12'd1;
    end
    if (res.last) clear_raster();
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    bit [DIM_W-1:0] v;
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    v = (val == '0) ? 13'd1 : val;
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = (v > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : v;
    end else begin
      img_h = (v > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : v;
    end
    clear_raster();
  endtask

  task automatic send_item(input blur_op_e op, input bit [7:0] red, green, blue,
                           input bit typed = 1'b0, input blur_result_t want = '0);
    bit           ignored;
    bit           produced;
    blur_result_t res;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    box_mean_step(op, {red, green, blue}, ignored, produced, res);
    if (produced) pending_means.push_back(typed ? want : res);
    if (!ignored) useful_items++;
  endtask

  // One image in raster order, then the drain, cut short after stop_at items
  // when stop_at is not negative.
  task automatic send_image(input int w, input int h, input int stop_at);
    int total;
    total = w * h + w + 1;
    for (int i = 0; i < total; i++) begin
      if (stop_at >= 0 && i >= stop_at) break;
      if (i < w * h) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
        end
        send_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      end else begin
        send_item(blur_op_e'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold      <= rdy_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      rdy_hold      <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    blur_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_means.size() == 0) begin
        $error("result with no expected item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, m_axis_tdata[23:16]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_pixel: expected %0d, actual %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("box_blur_3x3_rgb_top test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int w;
    int h;
    int style;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 20;
    stall_pct = 20;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      end else begin
        send_item(dir_table[i].op, dir_table[i].red, dir_table[i].green, dir_table[i].blue,
                  dir_table[i].typed, dir_table[i].want);
      end
    end

    // Opening items of the widest row and the tallest column, both written
    // above the legal range.
    gap_pct   = 10;
    stall_pct = 10;
    write_reg(REG_IMAGE_WIDTH, 13'd8191);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    send_image(MAX_WIDTH, 1, LARGE_ITEMS);
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd4097);
    send_image(1, MAX_HEIGHT, LARGE_ITEMS);

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items >= RANDOM_ITEMS - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      write_reg(REG_IMAGE_WIDTH, 13'(w));
      write_reg(REG_IMAGE_HEIGHT, 13'(h));
      style = $urandom_range(0, 9);
      if (style < 7) begin
        repeat ($urandom_range(1, 2)) send_image(w, h, -1);
      end else if (style < 9) begin
        send_image(w, h, $urandom_range(0, w * h + w));
      end else begin
        repeat ($urandom_range(1, 2 * w * h + w)) begin
          send_item(blur_op_e'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("box_blur_3x3_rgb_top test passed");
    end else begin
      $display("box_blur_3x3_rgb_top test failed");
    end
    $finish;
  end

endmodule

[box_blur_3x3_rgb_top.f]
+incdir+hdl
hdl/bb3_pkg.sv
hdl/bb3_line_store.sv
hdl/bb3_window.sv
hdl/box_blur_3x3_rgb_top.sv
tb/sv/testbench.sv
